// ===== design/load_cell_adc_serial_reader_top_defines.svh =====
// Assertion macros for the load-cell converter reader checker.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef LOAD_CELL_ADC_SERIAL_READER_TOP_DEFINES_SVH
`define LOAD_CELL_ADC_SERIAL_READER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LCASR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LCASR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lcasr_pkg.sv =====
// Shared types and constants for the load-cell converter reader.
// No dependencies.
package lcasr_pkg;

  localparam int SCALE_W    = 16;
  localparam int LIMIT_W    = 24;
  localparam int HALF_W     = 8;
  localparam int OUT_W      = 24;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;

  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_SCALE_DIVISOR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OVERWEIGHT_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD      = 2'd2;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd430;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'd20000;
  localparam logic [HALF_W-1:0]  HALF_RESET  = 8'd1;

  typedef enum logic [2:0] {
    PH_WAIT = 3'b001,
    PH_HIGH = 3'b010,
    PH_LOW  = 3'b100
  } phase_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== design/load_cell_adc_serial_reader_top.sv =====
// A non-finishing tick is registered in the output register in the cycle after it is accepted.
// The tick that completes a reading waits for the bit-serial divider, which produces one
// quotient bit per cycle; all other ticks sustain one per cycle unless the result is stalled.
// One output register: a tick is accepted while a finished result is being transferred.
// Reset (synchronous, active low): waiting for ready, readings zero, registers to defaults.
module load_cell_adc_serial_reader_top #(
  parameter int DATA_BITS    = 24,
  parameter int EXTRA_PULSES = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [lcasr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lcasr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_data_level,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_clock_level,
  output logic                              out_sample_valid,
  output logic [lcasr_pkg::OUT_W-1:0]       out_raw_reading,
  output logic [lcasr_pkg::OUT_W-1:0]       out_scaled_weight,
  output logic                              out_overweight
);

  localparam int TOTAL = DATA_BITS + EXTRA_PULSES;
  localparam int CW    = $clog2(TOTAL + 1);
  localparam int QW    = (DATA_BITS > lcasr_pkg::OUT_W) ? DATA_BITS : lcasr_pkg::OUT_W;
  localparam logic [DATA_BITS-1:0] TOP_BIT = DATA_BITS'(1) << (DATA_BITS - 1);

  localparam int HW = lcasr_pkg::HALF_W;

  // configuration
  logic [lcasr_pkg::SCALE_W-1:0] scale_r;
  logic [lcasr_pkg::LIMIT_W-1:0] limit_r;
  logic [HW-1:0]                 half_r;

  // sequencer state
  lcasr_pkg::phase_t    phase_r, phase_nxt;
  logic [CW-1:0]        bit_cnt_r, bit_cnt_nxt;
  logic [DATA_BITS-1:0] shift_r, shift_nxt;
  logic [HW-1:0]        timer_r, timer_nxt;

  // readings and output register
  logic [lcasr_pkg::OUT_W-1:0] last_raw_r;
  logic [lcasr_pkg::OUT_W-1:0] last_scaled_r;
  logic                        ovw_r;
  logic                        word_zero_r;
  logic                        out_valid_r;
  logic                        out_clock_level_r;
  logic                        out_sample_valid_r;

  logic                 in_acc;
  logic                 clk_lvl;
  logic                 finish;
  logic [HW-1:0]        hp;
  logic [HW:0]          t_inc;
  logic                 tick_done;
  logic [DATA_BITS-1:0] word;
  logic [QW-1:0]        word_ext;

  logic [DATA_BITS-1:0]          div_q;
  logic [QW-1:0]                 q_ext;
  logic [lcasr_pkg::SCALE_W-1:0] div_in;
  lcasr_pkg::div_stat_t          div_stat;

  assign in_ready = !div_stat.busy && !div_stat.done && (!out_valid_r || out_ready);
  assign in_acc   = in_valid && in_ready;

  assign hp        = (half_r == '0) ? HW'(1) : half_r;
  assign t_inc     = {1'b0, timer_r} + (HW+1)'(1);
  assign tick_done = t_inc >= {1'b0, hp};

  always_comb begin
    phase_nxt   = phase_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    timer_nxt   = timer_r;
    clk_lvl     = 1'b0;
    finish      = 1'b0;
    case (phase_r)
      lcasr_pkg::PH_HIGH: begin
        clk_lvl = 1'b1;
        if (tick_done) begin
          timer_nxt = '0;
          phase_nxt = lcasr_pkg::PH_LOW;
        end else begin
          timer_nxt = t_inc[HW-1:0];
        end
      end
      lcasr_pkg::PH_LOW: begin
        if (tick_done) begin
          timer_nxt = '0;
          // sample on the last tick of the low phase; extra pulses are not sampled
          if (bit_cnt_r < CW'(DATA_BITS)) begin
            shift_nxt = {shift_r[DATA_BITS-2:0], in_data_level};
          end
          bit_cnt_nxt = bit_cnt_r + CW'(1);
          if (bit_cnt_nxt >= CW'(TOTAL)) begin
            finish      = 1'b1;
            bit_cnt_nxt = '0;
            phase_nxt   = lcasr_pkg::PH_WAIT;
          end else begin
            phase_nxt = lcasr_pkg::PH_HIGH;
          end
        end else begin
          timer_nxt = t_inc[HW-1:0];
        end
      end
      lcasr_pkg::PH_WAIT: begin
        timer_nxt = '0;
        if (!in_data_level) begin
          phase_nxt   = lcasr_pkg::PH_HIGH;
          bit_cnt_nxt = '0;
          shift_nxt   = '0;
        end
      end
      default: begin
        phase_nxt = lcasr_pkg::PH_WAIT;
        timer_nxt = '0;
      end
    endcase
  end

  assign word     = shift_nxt ^ TOP_BIT;
  assign word_ext = QW'(word);
  assign div_in   = (scale_r == '0) ? lcasr_pkg::SCALE_W'(1) : scale_r;
  assign q_ext    = QW'(div_q);

  lcasr_div #(
    .DATA_BITS (DATA_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc && finish),
    .dividend (word),
    .divisor  (div_in),
    .quotient (div_q),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= lcasr_pkg::SCALE_RESET;
      limit_r <= lcasr_pkg::LIMIT_RESET;
      half_r  <= lcasr_pkg::HALF_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lcasr_pkg::REG_SCALE_DIVISOR:    scale_r <= cfg_wdata[lcasr_pkg::SCALE_W-1:0];
        lcasr_pkg::REG_OVERWEIGHT_LIMIT: limit_r <= cfg_wdata[lcasr_pkg::LIMIT_W-1:0];
        lcasr_pkg::REG_HALF_PERIOD:      half_r  <= cfg_wdata[HW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= lcasr_pkg::PH_WAIT;
      bit_cnt_r     <= '0;
      shift_r       <= '0;
      timer_r       <= '0;
      last_raw_r    <= '0;
      last_scaled_r <= '0;
      ovw_r         <= 1'b0;
      word_zero_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      // a finishing tick stays silent until the divider is done
      if (div_stat.done || (in_acc && !finish)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc) begin
        phase_r   <= phase_nxt;
        bit_cnt_r <= bit_cnt_nxt;
        shift_r   <= shift_nxt;
        timer_r   <= timer_nxt;
        if (finish) begin
          // hold the result until the divider finishes
          last_raw_r  <= word_ext[lcasr_pkg::OUT_W-1:0];
          word_zero_r <= (word == '0);
        end
      end
      if (div_stat.done) begin
        last_scaled_r <= (q_ext > QW'(lcasr_pkg::OUT_MAX)) ? lcasr_pkg::OUT_MAX
                                                           : q_ext[lcasr_pkg::OUT_W-1:0];
        if (!word_zero_r) begin
          ovw_r <= q_ext > QW'(limit_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !finish) begin
      out_clock_level_r  <= clk_lvl;
      out_sample_valid_r <= 1'b0;
    end else if (div_stat.done) begin
      out_clock_level_r  <= 1'b0;
      out_sample_valid_r <= 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_clock_level   = out_clock_level_r;
  assign out_sample_valid  = out_sample_valid_r;
  assign out_raw_reading   = last_raw_r;
  assign out_scaled_weight = last_scaled_r;
  assign out_overweight    = ovw_r;

endmodule

// ===== design/lcasr_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// Depends on lcasr_pkg for the status struct and divisor width.
module lcasr_div #(
  parameter int DATA_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [DATA_BITS-1:0]        dividend,
  input  logic [lcasr_pkg::SCALE_W-1:0] divisor,
  output logic [DATA_BITS-1:0]        quotient,
  output lcasr_pkg::div_stat_t        stat
);

  localparam int CNT_W = $clog2(DATA_BITS + 1);

  logic                          busy_r;
  logic                          done_r;
  logic [CNT_W-1:0]              cnt_r;
  logic [lcasr_pkg::SCALE_W-1:0] rem_r;
  logic [lcasr_pkg::SCALE_W-1:0] div_r;
  logic [DATA_BITS-1:0]          dq_r;

  logic [lcasr_pkg::SCALE_W:0]   trial;
  logic [lcasr_pkg::SCALE_W:0]   diff;
  logic                          fits;
  logic [lcasr_pkg::SCALE_W-1:0] rem_nxt;

  // Bring down the next dividend bit and try a subtract.
  assign trial   = {rem_r, dq_r[DATA_BITS-1]};
  assign fits    = trial >= {1'b0, div_r};
  assign diff    = trial - {1'b0, div_r};
  assign rem_nxt = fits ? diff[lcasr_pkg::SCALE_W-1:0] : trial[lcasr_pkg::SCALE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DATA_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts out the top while quotient bits shift in at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      div_r <= divisor;
      dq_r  <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dq_r  <= {dq_r[DATA_BITS-2:0], fits};
    end
  end

  assign quotient  = dq_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== design/lcasr_checker.sv =====
// Port-level checks for the load-cell converter reader, bound to the top level.
// Depends on load_cell_adc_serial_reader_top_defines.svh for the assertion macros.
`include "load_cell_adc_serial_reader_top_defines.svh"

module lcasr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_clock_level,
  input logic        out_sample_valid,
  input logic [23:0] out_raw_reading,
  input logic [23:0] out_scaled_weight
);

  // A completed reading is always reported with the serial clock low.
  `LCASR_ASSERT_NOW(a_sample_clk_low, out_valid && out_sample_valid, !out_clock_level, "sample with clock high")

  // One result slot: a stalled result blocks new ticks.
  `LCASR_ASSERT_NOW(a_stall_blocks_in, out_valid && !out_ready, !in_ready, "tick taken while result stalled")

  // A stalled result keeps its reading.
  `LCASR_ASSERT_NEXT(a_hold_raw, out_valid && !out_ready, out_valid && $stable(out_raw_reading), "stalled reading changed")

  // The weight cannot move right after a reading is transferred.
  `LCASR_ASSERT_NEXT(a_weight_settles, out_valid && out_ready && out_sample_valid, $stable(out_scaled_weight), "weight changed after transfer")

endmodule

bind load_cell_adc_serial_reader_top lcasr_checker u_lcasr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_clock_level   (out_clock_level),
  .out_sample_valid  (out_sample_valid),
  .out_raw_reading   (out_raw_reading),
  .out_scaled_weight (out_scaled_weight)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for load_cell_adc_serial_reader_top: drives data-line ticks,
// predicts the serial clock, the readings and the overweight flag, checks each transfer.
// Depends on lcasr_pkg and the load-cell reader RTL.
module tb_top;

  localparam int READ_BITS    = 24;
  localparam int TRAIL_PULSES = 1;
  localparam int ITEM_TARGET  = 1350;
  localparam logic [lcasr_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic                        clk_lvl;
    logic                        smp_valid;
    logic [lcasr_pkg::OUT_W-1:0] raw;
    logic [lcasr_pkg::OUT_W-1:0] scaled;
    logic                        over;
  } tick_out_t;

  typedef struct packed {
    logic      lvl;
    logic      typed;
    tick_out_t want;
  } bringup_row_t;

  localparam tick_out_t CLK_LO = '0;
  localparam tick_out_t CLK_HI = '{1'b1, 1'b0, '0, '0, 1'b0};

  // Bring-up sequence at reset settings: line busy, then ready, then the first pulses.
  localparam bringup_row_t BRINGUP [18] = '{
    '{1'b1, 1'b1, CLK_LO},
    '{1'b1, 1'b1, CLK_LO},
    '{1'b1, 1'b1, CLK_LO},
    '{1'b0, 1'b1, CLK_LO},
    '{1'b1, 1'b1, CLK_HI},
    '{1'b1, 1'b1, CLK_LO},
    '{1'b0, 1'b1, CLK_HI},
    '{1'b0, 1'b1, CLK_LO},
    '{1'b1, 1'b1, CLK_HI},
    '{1'b1, 1'b1, CLK_LO},
    '{1'b0, 1'b1, CLK_HI},
    '{1'b0, 1'b1, CLK_LO},
    '{1'b1, 1'b1, CLK_HI},
    '{1'b0, 1'b1, CLK_LO},
    '{1'b1, 1'b0, CLK_LO},
    '{1'b1, 1'b0, CLK_LO},
    '{1'b0, 1'b0, CLK_LO},
    '{1'b1, 1'b0, CLK_LO}
  };

  logic                             clk;
  logic                             rst_n         = 1'b0;
  logic                             cfg_wr_en     = 1'b0;
  logic [lcasr_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [lcasr_pkg::CFG_DATA_W-1:0] cfg_wdata     = '0;
  logic                             in_valid      = 1'b0;
  logic                             in_ready;
  logic                             in_data_level = 1'b1;
  logic                             out_valid;
  logic                             out_ready     = 1'b0;
  logic                             out_clock_level;
  logic                             out_sample_valid;
  logic [lcasr_pkg::OUT_W-1:0]      out_raw_reading;
  logic [lcasr_pkg::OUT_W-1:0]      out_scaled_weight;
  logic                             out_overweight;

  // predicted reader state and settings
  logic [lcasr_pkg::SCALE_W-1:0] cal_divisor;
  logic [lcasr_pkg::LIMIT_W-1:0] wt_limit;
  logic [lcasr_pkg::HALF_W-1:0]  half_ticks;
  lcasr_pkg::phase_t             rd_phase;
  int                            pulse_cnt;
  logic [READ_BITS-1:0]          shift_acc;
  logic [lcasr_pkg::HALF_W-1:0]  tick_timer;
  logic [lcasr_pkg::OUT_W-1:0]   held_raw;
  logic [lcasr_pkg::OUT_W-1:0]   held_scaled;
  logic                          held_over;

  logic [READ_BITS-1:0] target_word = '0;
  logic [READ_BITS-1:0] word_plan [$];
  tick_out_t            expected_ticks [$];
  int                   items_sent = 0;
  int                   faults     = 0;
  int                   sink_hold  = 0;
  bit                   src_steady = 1'b0;
  bit                   snk_steady = 1'b0;

  load_cell_adc_serial_reader_top #(
    .DATA_BITS   (READ_BITS),
    .EXTRA_PULSES(TRAIL_PULSES)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_level    (in_data_level),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_clock_level  (out_clock_level),
    .out_sample_valid (out_sample_valid),
    .out_raw_reading  (out_raw_reading),
    .out_scaled_weight(out_scaled_weight),
    .out_overweight   (out_overweight)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // True when the current clock phase ends on this tick; a zero half period counts as one.
  function automatic bit half_expires();
    logic [lcasr_pkg::HALF_W-1:0] span;
    span = (half_ticks == '0) ? lcasr_pkg::HALF_W'(1) : half_ticks;
    return (int'(tick_timer) + 1) >= int'(span);
  endfunction

  function automatic tick_out_t reader_tick(input logic lvl);
    tick_out_t   r;
    bit          expires;
    logic [63:0] word;
    logic [63:0] quot;
    r       = '0;
    expires = half_expires();
    if (rd_phase == lcasr_pkg::PH_WAIT) tick_timer = '0;
    else tick_timer = expires ? '0 : tick_timer + 1'b1;
    case (rd_phase)
      lcasr_pkg::PH_HIGH: begin
        r.clk_lvl = 1'b1;
        if (expires) rd_phase = lcasr_pkg::PH_LOW;
      end
      lcasr_pkg::PH_LOW: begin
        if (expires) begin
          if (pulse_cnt < READ_BITS) shift_acc = {shift_acc[READ_BITS-2:0], lvl};
          pulse_cnt++;
          if (pulse_cnt >= READ_BITS + TRAIL_PULSES) begin
            // flip the sign bit for offset binary, then scale
            word     = 64'(shift_acc) ^ (64'd1 << (READ_BITS - 1));
            held_raw = word[lcasr_pkg::OUT_W-1:0];
            if (word == 0) begin
              held_scaled = '0;
            end else begin
              quot        = word / ((cal_divisor == '0) ? 64'd1 : 64'(cal_divisor));
              held_over   = (quot > 64'(wt_limit));
              held_scaled = (quot > 64'(lcasr_pkg::OUT_MAX)) ? lcasr_pkg::OUT_MAX
                                                             : quot[lcasr_pkg::OUT_W-1:0];
            end
            r.smp_valid = 1'b1;
            rd_phase    = lcasr_pkg::PH_WAIT;
            pulse_cnt   = 0;
          end else begin
            rd_phase = lcasr_pkg::PH_HIGH;
          end
        end
      end
      default: begin
        if (!lvl) begin
          rd_phase  = lcasr_pkg::PH_HIGH;
          pulse_cnt = 0;
          shift_acc = '0;
        end
      end
    endcase
    r.raw    = held_raw;
    r.scaled = held_scaled;
    r.over   = held_over;
    return r;
  endfunction

  // Mostly ready while waiting; on a sampling tick feed the planned word, MSB first.
  function automatic logic pick_level();
    if (rd_phase == lcasr_pkg::PH_WAIT) return ($urandom_range(0, 4) == 0);
    if (rd_phase == lcasr_pkg::PH_LOW && pulse_cnt < READ_BITS && half_expires())
      return target_word[READ_BITS-1-pulse_cnt];
    return logic'($urandom_range(0, 1));
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_tick(input logic lvl, input logic typed, input tick_out_t want);
    int        gap;
    tick_out_t predicted;
    if (items_sent % 64 == 0) begin
      src_steady = ($urandom_range(0, 4) == 0);
      snk_steady = ($urandom_range(0, 4) == 0);
    end
    gap = src_steady ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_level <= lvl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = reader_tick(lvl);
    expected_ticks.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic run_ticks(input int n);
    logic lvl;
    repeat (n) begin
      lvl = pick_level();
      if (rd_phase == lcasr_pkg::PH_WAIT && !lvl) begin
        if (word_plan.size() != 0) begin
          target_word = word_plan.pop_front();
        end else begin
          case ($urandom_range(0, 7))
            0:       target_word = '0;
            1:       target_word = '1;
            2:       target_word = READ_BITS'(1) << (READ_BITS - 1);
            3:       target_word = ~(READ_BITS'(1) << (READ_BITS - 1));
            default: target_word = READ_BITS'($urandom);
          endcase
        end
      end
      send_tick(lvl, 1'b0, '0);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
  endtask

  task automatic configure(input logic [lcasr_pkg::CFG_DATA_W-1:0] div_w,
                           input logic [lcasr_pkg::CFG_DATA_W-1:0] lim_w,
                           input logic [lcasr_pkg::CFG_DATA_W-1:0] half_w,
                           input bit poke_spare);
    logic [lcasr_pkg::CFG_IDX_W-1:0]  idx [4];
    logic [lcasr_pkg::CFG_DATA_W-1:0] val [4];
    idx = '{lcasr_pkg::REG_SCALE_DIVISOR, lcasr_pkg::REG_OVERWEIGHT_LIMIT,
            lcasr_pkg::REG_HALF_PERIOD, REG_SPARE};
    val = '{div_w, lim_w, half_w, lcasr_pkg::CFG_DATA_W'($urandom)};
    drain();
    for (int i = 0; i < (poke_spare ? 4 : 3); i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      case (idx[i])
        lcasr_pkg::REG_SCALE_DIVISOR:    cal_divisor = val[i][lcasr_pkg::SCALE_W-1:0];
        lcasr_pkg::REG_OVERWEIGHT_LIMIT: wt_limit    = val[i][lcasr_pkg::LIMIT_W-1:0];
        lcasr_pkg::REG_HALF_PERIOD:      half_ticks  = val[i][lcasr_pkg::HALF_W-1:0];
        default: ;
      endcase
    end
    cfg_wr_en <= 1'b0;
  endtask

  // Result side: random stalls, with quiet stretches.
  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
    end else if (!snk_steady && $urandom_range(0, 2) == 0) begin
      out_ready <= 1'b0;
      sink_hold <= gap_len();
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    tick_out_t got;
    tick_out_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_clock_level, out_sample_valid, out_raw_reading, out_scaled_weight,
              out_overweight};
      if (expected_ticks.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("unexpected transfer: clk %b valid %b raw %h weight %h over %b",
                   got.clk_lvl, got.smp_valid, got.raw, got.scaled, got.over);
      end else begin
        want = expected_ticks.pop_front();
        if (got !== want) begin
          faults++;
          if (faults <= 10)
            $display("mismatch exp/got: clk %b/%b valid %b/%b raw %h/%h weight %h/%h over %b/%b",
                     want.clk_lvl, got.clk_lvl, want.smp_valid, got.smp_valid,
                     want.raw, got.raw, want.scaled, got.scaled, want.over, got.over);
        end
      end
    end
  end

  initial begin
    int div;
    int lim;
    int hp;
    cal_divisor = lcasr_pkg::SCALE_RESET;
    wt_limit    = lcasr_pkg::LIMIT_RESET;
    half_ticks  = lcasr_pkg::HALF_RESET;
    rd_phase    = lcasr_pkg::PH_WAIT;
    pulse_cnt   = 0;
    shift_acc   = '0;
    tick_timer  = '0;
    held_raw    = '0;
    held_scaled = '0;
    held_over   = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (BRINGUP[i]) send_tick(BRINGUP[i].lvl, BRINGUP[i].typed, BRINGUP[i].want);

    // reset settings: full-scale sets the flag, a zero reading keeps it, mid-scale clears it
    word_plan = '{24'h7FFFFF, 24'h800000, 24'h000001, 24'h000000};
    run_ticks(200);

    // zero divisor and zero half period act as one; the spare index must be ignored
    configure(24'hA50000, 24'h000000, 24'h5A5A00, 1'b1);
    word_plan = '{24'hFFFFFF, 24'h800000, 24'h800001, 24'h000000};
    run_ticks(160);

    configure(24'h00FFFF, 24'hFFFFFF, 24'h000002, 1'b0);
    word_plan = '{24'hFFFFFF, 24'h000000, 24'h800000};
    run_ticks(220);

    // longest half period; the next phase cuts it short while a pulse is running
    configure(24'hFF0001, 24'h0000FF, 24'h0000FF, 1'b1);
    run_ticks(280);
    configure(24'h000003, 24'h2AAAAA, 24'h000003, 1'b0);
    run_ticks(120);

    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 3))
        0:       div = $urandom_range(0, 3);
        1:       div = $urandom_range(4, 64);
        default: div = $urandom_range(65, 65535);
      endcase
      lim = $urandom_range(0, 24'hFFFFFF / ((div == 0) ? 1 : div));
      hp  = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
      configure({8'($urandom), 16'(div)}, 24'(lim), {16'($urandom), 8'(hp)},
                1'($urandom_range(0, 1)));
      run_ticks($urandom_range(80, 160));
    end

    drain();
    repeat (READ_BITS + 8) @(posedge clk);
    if (faults == 0 && expected_ticks.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/lcasr_pkg.sv
design/lcasr_div.sv
design/load_cell_adc_serial_reader_top.sv
design/lcasr_checker.sv
test/tb_top.sv
